// File: design/cdq_pkg.sv
// Shared types and constants for the circular double-ended queue.
package cdq_pkg;

	localparam int DATA_W    = 32;
	localparam int FILL_W    = 11;
	localparam int DEPTH_DEF = 1024;

	typedef enum logic [1:0] {
		REQ_PUSH_FRONT = 2'd0,
		REQ_PUSH_BACK  = 2'd1,
		REQ_POP_FRONT  = 2'd2,
		REQ_POP_BACK   = 2'd3
	} cdq_req_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} cdq_status_t;

	// Strobes from the control logic to the word store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} cdq_mem_ctl_t;

endpackage

// File: design/cdq_if.sv
// Request and response channel interfaces of the queue.
interface cdq_req_if;
	import cdq_pkg::*;
	logic                     valid;
	logic                     ready;
	cdq_req_t                 req_type;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface cdq_rsp_if;
	import cdq_pkg::*;
	logic                     valid;
	logic                     ready;
	cdq_status_t              status;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] rear_value;
	logic [FILL_W-1:0]        fill_count;

	modport source (output valid, output status, output front_value, output rear_value,
		output fill_count, input ready);
	modport sink (input valid, input status, input front_value, input rear_value,
		input fill_count, output ready);
endinterface

// File: design/cdq_store.sv
// Word store: one write port, two registered read ports.
module cdq_store #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  cdq_pkg::cdq_mem_ctl_t            ctl,
	input  logic [AW-1:0]                    wr_addr,
	input  logic signed [cdq_pkg::DATA_W-1:0] wr_data,
	input  logic [AW-1:0]                    rd_addr_front,
	input  logic [AW-1:0]                    rd_addr_rear,
	output logic signed [cdq_pkg::DATA_W-1:0] rd_front,
	output logic signed [cdq_pkg::DATA_W-1:0] rd_rear
);
	import cdq_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];

	// Write a pushed word
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read front and rear words
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_front <= mem[rd_addr_front];
			rd_rear  <= mem[rd_addr_rear];
		end
	end

endmodule

// File: design/cdq_ctrl.sv
// Pointer, fill and sequencing logic with the response register.
module cdq_ctrl #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	cdq_req_if.sink                           req,
	cdq_rsp_if.source                         rsp,
	output cdq_pkg::cdq_mem_ctl_t             mem_ctl,
	output logic [AW-1:0]                     wr_addr,
	output logic signed [cdq_pkg::DATA_W-1:0] wr_data,
	output logic [AW-1:0]                     rd_addr_front,
	output logic [AW-1:0]                     rd_addr_rear,
	input  logic signed [cdq_pkg::DATA_W-1:0] rd_front,
	input  logic signed [cdq_pkg::DATA_W-1:0] rd_rear
);
	import cdq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_LD   = 3'b100
	} cdq_state_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cdq_state_t    state_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] fill_q;
	cdq_status_t   stat_q;

	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] fill_d;
	cdq_status_t   stat_d;
	logic          push_wr;
	logic          accept;
	logic          load_out;
	logic          out_valid_q;
	logic [FILL_W-1:0] fill_out;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign load_out  = (state_q == ST_LD) && (!out_valid_q || rsp.ready);

	// Work out the next pointers, fill and status of a request
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		fill_d  = fill_q;
		stat_d  = STAT_DONE;
		push_wr = 1'b0;
		wr_addr = tail_q;
		unique case (req.req_type)
			REQ_PUSH_FRONT: begin
				if (fill_q == FULL_CNT) begin
					stat_d = STAT_FULL;
				end else begin
					head_d  = wrap_dec(head_q);
					wr_addr = head_d;
					push_wr = 1'b1;
					fill_d  = fill_q + CW'(1);
				end
			end
			REQ_PUSH_BACK: begin
				if (fill_q == FULL_CNT) begin
					stat_d = STAT_FULL;
				end else begin
					wr_addr = tail_q;
					tail_d  = wrap_inc(tail_q);
					push_wr = 1'b1;
					fill_d  = fill_q + CW'(1);
				end
			end
			REQ_POP_FRONT: begin
				if (fill_q == '0) begin
					stat_d = STAT_EMPTY;
				end else begin
					head_d = wrap_inc(head_q);
					fill_d = fill_q - CW'(1);
				end
			end
			REQ_POP_BACK: begin
				if (fill_q == '0) begin
					stat_d = STAT_EMPTY;
				end else begin
					tail_d = wrap_dec(tail_q);
					fill_d = fill_q - CW'(1);
				end
			end
			default: begin
				stat_d = STAT_DONE;
			end
		endcase
	end

	assign wr_data        = req.push_value;
	assign mem_ctl.wr_en  = accept && push_wr;
	assign mem_ctl.rd_en  = (state_q == ST_RD);
	assign rd_addr_front  = head_q;
	assign rd_addr_rear   = wrap_dec(tail_q);

	// Fit the fill count to the response field
	generate
		if (CW >= FILL_W) begin : g_fill_trunc
			assign fill_out = fill_q[FILL_W-1:0];
		end else begin : g_fill_ext
			assign fill_out = {{(FILL_W - CW){1'b0}}, fill_q};
		end
	endgenerate

	// Advance the sequencer and hold the queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			stat_q  <= STAT_DONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q  <= head_d;
						tail_q  <= tail_d;
						fill_q  <= fill_d;
						stat_q  <= stat_d;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the response word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the response payload; drop the words of an empty queue
	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp.status      <= stat_q;
			rsp.fill_count  <= fill_out;
			rsp.front_value <= (fill_q == '0) ? '0 : rd_front;
			rsp.rear_value  <= (fill_q == '0) ? '0 : rd_rear;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

// File: design/circular_double_ended_queue.sv
// Top level of the circular double-ended queue.
//
// A request word on req carries req_type (push front, push back, pop front,
// pop back) and push_value. Each request yields exactly one response word on
// rsp with status (done, refused full, refused empty), the fill count and
// the words now at the front and rear, both zero when the queue is empty.
// Both channels move a word when valid and ready are high at a rising edge.
//
// One request is in flight at a time: the pointers update and a pushed word is
// written at the accepting edge, the store is read in state ST_RD and the
// response is loaded in state ST_LD, where it waits while the response register
// still holds an untaken word. The request side reopens with that load, so a new
// request is taken only once the last one is through. The sequence is set by the
// registered read of the word store, read after the pointers settle.
// A stalled receiver holds the response register; the next request is taken
// while that word waits, and its result waits in turn until the register frees.
// Reset (arst_n low) empties the queue and clears both pointers; the store
// itself is not cleared, as only pushed entries ever reach the response.
module circular_double_ended_queue #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cdq_req_if.sink   req,
	cdq_rsp_if.source rsp
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);

	cdq_mem_ctl_t             mem_ctl;
	logic [AW-1:0]            wr_addr, rd_addr_front, rd_addr_rear;
	logic signed [DATA_W-1:0] wr_data, rd_front, rd_rear;

	cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.mem_ctl       (mem_ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr_front (rd_addr_front),
		.rd_addr_rear  (rd_addr_rear),
		.rd_front      (rd_front),
		.rd_rear       (rd_rear)
	);

	cdq_store #(.DEPTH(DEPTH)) u_store (
		.clk           (clk),
		.ctl           (mem_ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr_front (rd_addr_front),
		.rd_addr_rear  (rd_addr_rear),
		.rd_front      (rd_front),
		.rd_rear       (rd_rear)
	);

endmodule

// File: design/cdq_checker.sv
// Port-level checks of the queue, bound to the top level.
module cdq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_front,
	input logic [31:0] rsp_rear,
	input logic [10:0] rsp_fill
);
	import cdq_pkg::*;

	// A stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_front) && $stable(rsp_rear) && $stable(rsp_fill))
		else $error("response word changed while stalled");

	// Only one request in flight: no acceptance in the cycle after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// An empty queue reports zero words
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_fill == '0 |-> rsp_front == '0 && rsp_rear == '0)
		else $error("empty queue reported a non-zero word");

	// A refused pop only comes from an empty queue
	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_EMPTY |-> rsp_fill == '0)
		else $error("pop refused on a non-empty queue");

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_front  (rsp.front_value),
	.rsp_rear   (rsp.rear_value),
	.rsp_fill   (rsp.fill_count)
);
